// ===== rtl/fomm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fomm_pkg
// Types, constants and the sine/cosine tables shared by the mecanum mixer.
// ----------------------------------------------------------------------------
package fomm_pkg;

	localparam int SINE_TABLE_ENTRIES = 256;
	localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES);
	localparam int HP_W = 16 + IDX_W;

	// quarter-wave polynomial coefficients, Q15
	localparam longint SIN_A = 51472;
	localparam longint SIN_B = 21024;
	localparam longint SIN_C = 2320;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STRAFE_DB  = 3'd0,
		REG_FORWARD_DB = 3'd1,
		REG_TURN_DB    = 3'd2,
		REG_STRAFE_GAIN = 3'd3,
		REG_TURN_GAIN  = 3'd4
	} cfg_reg_e;

	localparam logic [14:0] STRAFE_DB_RST  = 15'd4915;
	localparam logic [14:0] FORWARD_DB_RST = 15'd6554;
	localparam logic [14:0] TURN_DB_RST    = 15'd13107;
	localparam logic [15:0] STRAFE_GAIN_RST = 16'd26214;
	localparam logic [15:0] TURN_GAIN_RST  = 16'd21299;

	typedef struct packed {
		logic [14:0] strafe_db;
		logic [14:0] forward_db;
		logic [14:0] turn_db;
		logic [15:0] strafe_gain;
		logic [15:0] turn_gain;
	} cfg_t;

	// packed so that strafe lands in the low bits of tdata
	typedef struct packed {
		logic [15:0]        heading;
		logic signed [15:0] turn;
		logic signed [15:0] forward;
		logic signed [15:0] strafe;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] front_right;
		logic signed [15:0] back_right;
		logic signed [15:0] back_left;
		logic signed [15:0] front_left;
	} wheel_t;

	// deadband pass flags, one per axis
	typedef struct packed {
		logic x;
		logic y;
		logic z;
	} axis_on_t;

	// after rotation and rounding
	typedef struct packed {
		axis_on_t           on;
		logic signed [17:0] xr;
		logic signed [17:0] yr;
		logic signed [16:0] zq;
	} rot_t;

	// after squaring and gain scaling (strafe rounding still pending)
	typedef struct packed {
		axis_on_t           on;
		logic signed [34:0] sp;
		logic signed [17:0] yq;
		logic signed [18:0] tu;
	} shp_t;

	typedef logic signed [16:0] trig_t;
	typedef trig_t trig_lut_t [SINE_TABLE_ENTRIES];

	function automatic longint quarter_sine(longint x);
		longint x2;
		longint w;
		longint v;
		longint p;
		x2 = (x * x + 16384) >> 15;
		w = SIN_B - ((SIN_C * x2 + 16384) >> 15);
		v = (w * x2 + 16384) >> 15;
		p = SIN_A - v;
		return (x * p + 16384) >> 15;
	endfunction

	// q counts quarter turns in units of 1/SINE_TABLE_ENTRIES of a quarter
	function automatic longint table_sine(longint q);
		longint quad;
		longint rem;
		longint x;
		longint s;
		quad = (q / SINE_TABLE_ENTRIES) % 4;
		rem = q % SINE_TABLE_ENTRIES;
		x = (rem * 32768 + SINE_TABLE_ENTRIES / 2) / SINE_TABLE_ENTRIES;
		if (quad == 1 || quad == 3)
			x = 32768 - x;
		s = quarter_sine(x);
		return (quad >= 2) ? -s : s;
	endfunction

	function automatic trig_lut_t build_lut(bit cosine);
		trig_lut_t lut;
		longint q;
		for (int i = 0; i < SINE_TABLE_ENTRIES; i++) begin
			q = 4 * longint'(i) + (cosine ? longint'(SINE_TABLE_ENTRIES) : 0);
			lut[i] = trig_t'(table_sine(q));
		end
		return lut;
	endfunction

	localparam trig_lut_t SIN_LUT = build_lut(1'b0);
	localparam trig_lut_t COS_LUT = build_lut(1'b1);

	function automatic logic signed [16:0] mag16(logic signed [15:0] v);
		logic signed [16:0] w;
		w = 17'(v);
		return v[15] ? -w : w;
	endfunction

	function automatic logic signed [15:0] sat16(logic signed [20:0] v);
		if (v > 21'sd32767)
			return 16'sh7fff;
		else if (v < -21'sd32768)
			return 16'sh8000;
		else
			return v[15:0];
	endfunction

endpackage

// ===== rtl/fomm_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fomm_cfg
// Deadband and gain register file; write only, unknown indexes are dropped.
// ----------------------------------------------------------------------------
module fomm_cfg
	import fomm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.strafe_db   <= STRAFE_DB_RST;
			cfg_q.forward_db  <= FORWARD_DB_RST;
			cfg_q.turn_db     <= TURN_DB_RST;
			cfg_q.strafe_gain <= STRAFE_GAIN_RST;
			cfg_q.turn_gain   <= TURN_GAIN_RST;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_STRAFE_DB:   cfg_q.strafe_db   <= cfg_wdata[14:0];
				REG_FORWARD_DB:  cfg_q.forward_db  <= cfg_wdata[14:0];
				REG_TURN_DB:     cfg_q.turn_db     <= cfg_wdata[14:0];
				REG_STRAFE_GAIN: cfg_q.strafe_gain <= cfg_wdata;
				REG_TURN_GAIN:   cfg_q.turn_gain   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/fomm_rotate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fomm_rotate
// Stages 1-3: table lookup and deadband tests, rotation products, rounding.
// ----------------------------------------------------------------------------
module fomm_rotate
	import fomm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    in_valid,
	output logic    in_ready,
	input  sample_t in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output rot_t    out_data
);

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	logic [HP_W-1:0]  head_prod;
	logic [IDX_W-1:0] idx;

	logic signed [15:0] x_s1, y_s1, z_s1;
	trig_t              sin_s1, cos_s1;
	axis_on_t           on_s1, on_s2;

	logic signed [32:0] pxc_s2, pys_s2, pxs_s2, pyc_s2, zz_s2;
	logic signed [16:0] zmag;

	logic signed [33:0] rx, ry;
	logic signed [32:0] rz;
	rot_t               rot_s3;

	assign rdy3 = !v_s3 || out_ready;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	assign head_prod = HP_W'(in_data.heading) * HP_W'(SINE_TABLE_ENTRIES);
	assign idx = head_prod[16 +: IDX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	// stage 1: sine/cosine lookup, deadband tests on the raw axes
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			x_s1   <= in_data.strafe;
			y_s1   <= in_data.forward;
			z_s1   <= in_data.turn;
			sin_s1 <= SIN_LUT[idx];
			cos_s1 <= COS_LUT[idx];
			on_s1.x <= mag16(in_data.strafe)  > {2'b00, cfg.strafe_db};
			on_s1.y <= mag16(in_data.forward) > {2'b00, cfg.forward_db};
			on_s1.z <= mag16(in_data.turn)    > {2'b00, cfg.turn_db};
		end
	end

	// stage 2: rotation products, signed square of turn
	assign zmag = mag16(z_s1);

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			pxc_s2 <= x_s1 * cos_s1;
			pys_s2 <= y_s1 * sin_s1;
			pxs_s2 <= x_s1 * sin_s1;
			pyc_s2 <= y_s1 * cos_s1;
			zz_s2  <= z_s1 * zmag;
			on_s2  <= on_s1;
		end
	end

	// stage 3: combine and round; rotated axes stay unsaturated
	assign rx = (34'(pxc_s2) - 34'(pys_s2)) + 34'sd16384;
	assign ry = (34'(pxs_s2) + 34'(pyc_s2)) + 34'sd16384;
	assign rz = zz_s2 + 33'sd16384;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			rot_s3.on <= on_s2;
			rot_s3.xr <= rx[32:15];
			rot_s3.yr <= ry[32:15];
			rot_s3.zq <= rz[31:15];
		end
	end

	assign out_valid = v_s3;
	assign out_data = rot_s3;

endmodule

// ===== rtl/fomm_shape.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fomm_shape
// Stages 4-6: signed squares of the rotated axes and turn gain, rounding, strafe gain.
// ----------------------------------------------------------------------------
module fomm_shape
	import fomm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  rot_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output shp_t out_data
);

	logic v_s4, v_s5, v_s6;
	logic rdy4, rdy5, rdy6;

	logic signed [18:0] xmag, ymag;
	logic signed [33:0] xx_s4, yy_s4, zt_s4;
	axis_on_t           on_s4, on_s5;

	logic signed [33:0] rxx, ryy, rzt;
	logic signed [17:0] xq_s5, yq_s5;
	logic signed [18:0] tu_s5;

	shp_t shp_s6;

	assign rdy6 = !v_s6 || out_ready;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign in_ready = rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy4) v_s4 <= in_valid;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	assign xmag = in_data.xr[17] ? -19'(in_data.xr) : 19'(in_data.xr);
	assign ymag = in_data.yr[17] ? -19'(in_data.yr) : 19'(in_data.yr);

	// stage 4: squares keep the sign; turn term already squared upstream
	always_ff @(posedge clk) begin
		if (rdy4 && in_valid) begin
			xx_s4 <= in_data.xr * xmag;
			yy_s4 <= in_data.yr * ymag;
			zt_s4 <= in_data.zq * $signed({1'b0, cfg.turn_gain});
			on_s4 <= in_data.on;
		end
	end

	// stage 5: round
	assign rxx = xx_s4 + 34'sd16384;
	assign ryy = yy_s4 + 34'sd16384;
	assign rzt = zt_s4 + 34'sd16384;

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			xq_s5 <= rxx[32:15];
			yq_s5 <= ryy[32:15];
			tu_s5 <= rzt[33:15];
			on_s5 <= on_s4;
		end
	end

	// stage 6: strafe gain
	always_ff @(posedge clk) begin
		if (rdy6 && v_s5) begin
			shp_s6.sp <= xq_s5 * $signed({1'b0, cfg.strafe_gain});
			shp_s6.yq <= yq_s5;
			shp_s6.tu <= tu_s5;
			shp_s6.on <= on_s5;
		end
	end

	assign out_valid = v_s6;
	assign out_data = shp_s6;

endmodule

// ===== rtl/fomm_mix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fomm_mix
// Stage 7: strafe rounding, deadband gating, four-wheel mix, saturation into the output register.
// ----------------------------------------------------------------------------
module fomm_mix
	import fomm_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  shp_t   in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output wheel_t out_data
);

	logic   v_s7;
	wheel_t whl_s7;

	logic signed [34:0] rsp;
	logic signed [20:0] st, fw, tu;
	logic signed [20:0] sum_fl, sum_bl, sum_br, sum_fr;

	assign in_ready = !v_s7 || out_ready;

	assign rsp = in_data.sp + 35'sd16384;
	assign st = in_data.on.x ? 21'($signed(rsp[33:15])) : 21'sd0;
	assign fw = in_data.on.y ? 21'(in_data.yq) : 21'sd0;
	assign tu = in_data.on.z ? 21'(in_data.tu) : 21'sd0;

	assign sum_fl = -st + fw - tu;
	assign sum_bl =  st + fw - tu;
	assign sum_br =  st - fw - tu;
	assign sum_fr = -st - fw - tu;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else if (in_ready)
			v_s7 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			whl_s7.front_left  <= sat16(sum_fl);
			whl_s7.back_left   <= sat16(sum_bl);
			whl_s7.back_right  <= sat16(sum_br);
			whl_s7.front_right <= sat16(sum_fr);
		end
	end

	assign out_valid = v_s7;
	assign out_data = whl_s7;

endmodule

// ===== rtl/field_oriented_mecanum_mixer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// field_oriented_mecanum_mixer_core
// Field-oriented mecanum mixer: joystick sample in, four wheel drives out.
// ----------------------------------------------------------------------------
// The core takes one sample per clock while not stalled and returns one set of
// four wheel drives, in order. The seven register stages are: sine/cosine
// table lookup, rotation multiplies, rotation rounding, signed squares,
// rounding, strafe gain multiply, and the mix/saturate output register. Ready
// ripples back stage by stage, so empty stages keep filling while a result
// waits at the output. Deadband and gain registers may be written any time the
// core is idle; they are sampled as a sample passes the stage that uses them.
module field_oriented_mecanum_mixer_core
	import fomm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// strafe_axis[15:0], forward_axis[31:16], turn_axis[47:32], heading[63:48]
	input  logic [63:0]           s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// front_left[15:0], back_left[31:16], back_right[47:32], front_right[63:48]
	output logic [63:0]           m_axis_tdata
);

	cfg_t   cfg;
	logic   rot_valid, rot_ready;
	rot_t   rot_data;
	logic   shp_valid, shp_ready;
	shp_t   shp_data;
	wheel_t whl_data;

	fomm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	fomm_rotate u_rotate (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (sample_t'(s_axis_tdata)),
		.out_valid (rot_valid),
		.out_ready (rot_ready),
		.out_data  (rot_data)
	);

	fomm_shape u_shape (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (rot_valid),
		.in_ready  (rot_ready),
		.in_data   (rot_data),
		.out_valid (shp_valid),
		.out_ready (shp_ready),
		.out_data  (shp_data)
	);

	fomm_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (shp_valid),
		.in_ready  (shp_ready),
		.in_data   (shp_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (whl_data)
	);

	assign m_axis_tdata = whl_data;

endmodule
